[hdl/ebsa_pkg.sv]
// ----------------------------------------------------------------------------
// ebsa_pkg
// Shared types and defaults for the bilinear splat event accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package ebsa_pkg;

  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 256;
  localparam int unsigned DefFracBits  = 8;

  localparam int unsigned CoordW   = 20;
  localparam int unsigned PixW     = 8;
  localparam int unsigned DimW     = 9;
  localparam int unsigned ValW     = 16;
  localparam logic [16:0] PixOne   = 17'd32768;

  typedef enum logic [1:0] {
    ActClear = 2'd0,
    ActLoad  = 2'd1,
    ActEvent = 2'd2,
    ActRead  = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } reg_idx_e;

endpackage

`default_nettype wire

[hdl/event_bilinear_splat_accumulator.sv]
// ----------------------------------------------------------------------------
// event_bilinear_splat_accumulator
// Splats events into a Q1.15 frame through a per-pixel rectification table.
// ----------------------------------------------------------------------------
//  channel   ports                                        transfer
//  command   start, busy, action_i, pixel_*_i, rect_*_i   start & !busy
//  result    result_valid_o, frame_pix_o                  result_valid_o
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i             cfg_we_i
//
//  Load stays idle; Read passes StOut. Event: lookup (StLook), then per
//  corner a read (StSpRd) and write (StSpWr) of the single-port frame
//  memory; an event outside the active area is dropped, one with an
//  invalid entry ends at the lookup. Clear: one frame word per cycle.
//  After reset the same clearing pass runs with busy high.
//  Results appear for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module event_bilinear_splat_accumulator #(
  parameter int unsigned MAX_WIDTH  = ebsa_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = ebsa_pkg::DefMaxHeight,
  parameter int unsigned FRAC_BITS  = ebsa_pkg::DefFracBits
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   action_i,
  input  wire logic [ebsa_pkg::PixW-1:0]    pixel_x_i,
  input  wire logic [ebsa_pkg::PixW-1:0]    pixel_y_i,
  input  wire logic signed [ebsa_pkg::CoordW-1:0] rect_x_i,
  input  wire logic signed [ebsa_pkg::CoordW-1:0] rect_y_i,
  output logic                              result_valid_o,
  output logic [ebsa_pkg::ValW-1:0]         frame_pix_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [0:0]                   cfg_idx_i,
  input  wire logic [ebsa_pkg::DimW-1:0]    cfg_wdata_i
);
  import ebsa_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CXW   = $clog2(MAX_WIDTH);
  localparam int unsigned CYW   = $clog2(MAX_HEIGHT);
  localparam int unsigned EW    = 1 + CXW + CYW + 2 * FRAC_BITS;
  localparam int unsigned IXW   = CoordW - FRAC_BITS;
  localparam int unsigned EDW   = 11;
  localparam int unsigned PW    = 2 * FRAC_BITS + 2;
  localparam int          SH    = 2 * FRAC_BITS - 15;
  localparam int unsigned SHR   = (SH > 0) ? SH : 0;
  localparam int unsigned SHL   = (SH < 0) ? -SH : 0;
  localparam logic [31:0] Rnd   = (SH > 0) ? (32'd1 << (SHR - 1)) : 32'd0;
  localparam logic [IXW-1:0] Bias = IXW'(1) << (IXW - 1);
  localparam logic [FRAC_BITS:0] One = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StClear = 6'b000010,
    StLook  = 6'b000100,
    StSpRd  = 6'b001000,
    StSpWr  = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0]  cnt_q, cnt_d;
  logic [1:0]     corner_q, corner_d;
  logic           in_area_q, in_area_d;
  logic [DimW-1:0] width_q, height_q;
  logic [ValW-1:0] weight_q;
  logic [ValW-1:0] weight_d;

  logic [EW-1:0]   tab_mem [Depth];
  logic [ValW-1:0] frm_mem [Depth];
  logic [EW-1:0]   tab_rdata_q;
  logic [ValW-1:0] frm_rdata_q;

  logic            tab_we, tab_re, frm_we, frm_re;
  logic [AW-1:0]   tab_addr, frm_addr;
  logic [EW-1:0]   tab_wdata;
  logic [ValW-1:0] frm_wdata;

  logic [EDW-1:0]  eff_w, eff_h;
  logic            in_area;
  logic [AW-1:0]   req_addr;
  logic [IXW-1:0]  ix, iy, ixo, iyo;
  logic            ent_ok;
  logic            ent_valid;
  logic [CXW-1:0]  ent_cx;
  logic [CYW-1:0]  ent_cy;
  logic [FRAC_BITS-1:0] ent_fx, ent_fy;
  logic [FRAC_BITS:0]   wx, wy;
  logic [PW-1:0]   prod;
  logic [31:0]     p32, q32;
  logic [AW-1:0]   corner_addr;
  logic [16:0]     sum;
  logic            accept;

  always_comb begin
    eff_w = EDW'(width_q);
    if (width_q < DimW'(2)) eff_w = EDW'(2);
    else if (EDW'(width_q) > EDW'(MAX_WIDTH)) eff_w = EDW'(MAX_WIDTH);
    eff_h = EDW'(height_q);
    if (height_q < DimW'(2)) eff_h = EDW'(2);
    else if (EDW'(height_q) > EDW'(MAX_HEIGHT)) eff_h = EDW'(MAX_HEIGHT);
  end

  assign in_area  = (EDW'(pixel_x_i) < eff_w) && (EDW'(pixel_y_i) < eff_h);
  assign req_addr = AW'(32'(pixel_y_i) * 32'(MAX_WIDTH) + 32'(pixel_x_i));
  assign accept   = start && !busy;

  // Load-time corner check: flipping the sign bit gives offset binary.
  assign ix  = IXW'({~rect_x_i[CoordW-1], rect_x_i[CoordW-2:0]} >> FRAC_BITS);
  assign iy  = IXW'({~rect_y_i[CoordW-1], rect_y_i[CoordW-2:0]} >> FRAC_BITS);
  assign ixo = ix - Bias;
  assign iyo = iy - Bias;
  assign ent_ok = (ix >= Bias) && (32'(ixo) < 32'(eff_w) - 32'd1) &&
                  (iy >= Bias) && (32'(iyo) < 32'(eff_h) - 32'd1);

  always_comb begin
    tab_wdata = '0;
    if (ent_ok) begin
      tab_wdata = {1'b1, CYW'(iyo), CXW'(ixo),
                   rect_y_i[FRAC_BITS-1:0], rect_x_i[FRAC_BITS-1:0]};
    end
  end

  assign {ent_valid, ent_cy, ent_cx, ent_fy, ent_fx} = tab_rdata_q;

  assign wx   = corner_q[0] ? {1'b0, ent_fx} : One - {1'b0, ent_fx};
  assign wy   = corner_q[1] ? {1'b0, ent_fy} : One - {1'b0, ent_fy};
  assign prod = PW'(wx) * PW'(wy);
  assign p32  = 32'(prod);
  assign q32  = (SH > 0) ? ((p32 + Rnd) >> SHR) : (p32 << SHL);
  assign weight_d = ValW'(q32);

  assign corner_addr = AW'((32'(ent_cy) + 32'(corner_q[1])) * 32'(MAX_WIDTH) +
                           32'(ent_cx) + 32'(corner_q[0]));
  assign sum = 17'(frm_rdata_q) + 17'(weight_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    corner_d  = corner_q;
    in_area_d = in_area_q;
    tab_we    = 1'b0;
    tab_re    = 1'b0;
    tab_addr  = req_addr;
    frm_we    = 1'b0;
    frm_re    = 1'b0;
    frm_addr  = req_addr;
    frm_wdata = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (action_e'(action_i))
            ActClear: begin
              cnt_d   = '0;
              state_d = StClear;
            end
            ActLoad: tab_we = in_area;
            ActEvent: begin
              if (in_area) begin
                tab_re  = 1'b1;
                state_d = StLook;
              end
            end
            ActRead: begin
              frm_re    = in_area;
              in_area_d = in_area;
              state_d   = StOut;
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StClear: begin
        frm_we   = 1'b1;
        frm_addr = cnt_q;
        cnt_d    = cnt_q + AW'(1);
        if (32'(cnt_q) == Depth - 1) state_d = StIdle;
      end
      StLook: begin
        corner_d = '0;
        state_d  = ent_valid ? StSpRd : StIdle;
      end
      StSpRd: begin
        frm_re   = 1'b1;
        frm_addr = corner_addr;
        state_d  = StSpWr;
      end
      StSpWr: begin
        frm_we    = 1'b1;
        frm_addr  = corner_addr;
        frm_wdata = (sum > PixOne) ? ValW'(PixOne) : ValW'(sum);
        corner_d  = corner_q + 2'd1;
        state_d   = (corner_q == 2'd3) ? StIdle : StSpRd;
      end
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      cnt_q     <= '0;
      corner_q  <= '0;
      in_area_q <= 1'b0;
      width_q   <= DimW'(256);
      height_q  <= DimW'(256);
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      corner_q  <= corner_d;
      in_area_q <= in_area_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          RegWidth:  width_q  <= cfg_wdata_i;
          RegHeight: height_q <= cfg_wdata_i;
          default:   width_q  <= width_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StSpRd) weight_q <= weight_d;
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_addr] <= tab_wdata;
    if (tab_re) tab_rdata_q <= tab_mem[tab_addr];
  end

  always_ff @(posedge clk_i) begin
    if (frm_we) frm_mem[frm_addr] <= frm_wdata;
    if (frm_re) frm_rdata_q <= frm_mem[frm_addr];
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = (state_q == StOut);
  assign frame_pix_o    = in_area_q ? frm_rdata_q : '0;

endmodule

`default_nettype wire
